// File: hdl/record_index_table_defines.svh
// assertion macros for the record index table checker
// no dependencies; included by the checker file
`ifndef RECORD_INDEX_TABLE_DEFINES_SVH
`define RECORD_INDEX_TABLE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RIT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define RIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rit_pkg.sv
// types, codes and constants shared by the record index table modules
// no dependencies
package rit_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH     = 2;
    localparam logic [15:0] STEP_BYTES_RST = 16'd64;

    localparam logic [2:0] OP_STORE    = 3'd0;
    localparam logic [2:0] OP_GET      = 3'd1;
    localparam logic [2:0] OP_UPDATE   = 3'd2;
    localparam logic [2:0] OP_DELETE   = 3'd3;
    localparam logic [2:0] OP_UNDELETE = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] location;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_STORE,
        CMD_FIND,
        CMD_DELETE,
        CMD_UNDELETE,
        CMD_BAD
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] key;
    } t_cmd_item;

    // key holds the original key for deleted entries as well
    typedef struct packed {
        logic        deleted;
        logic [31:0] key;
        logic [23:0] offset;
    } t_entry;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    function automatic t_cmd_item classify(input t_in_item req);
        t_cmd_item c;
        c.key = req.key;
        unique case (req.operation)
            OP_STORE:         c.cmd = CMD_STORE;
            OP_GET, OP_UPDATE: c.cmd = CMD_FIND;
            OP_DELETE:        c.cmd = CMD_DELETE;
            OP_UNDELETE:      c.cmd = CMD_UNDELETE;
            default:          c.cmd = CMD_BAD;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/rit_front.sv
// front stage: registers each request and decodes its operation
// depends on rit_pkg
module rit_front import rit_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_push,
    output t_cmd_item o_item,
    input  logic      i_q_ready
);

    logic      r_valid;
    t_cmd_item r_item;

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_push     = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= classify(i_in_data);
        end
    end

endmodule

// File: hdl/rit_queue.sv
// short fifo of decoded requests between front and back
// depends on rit_pkg
module rit_queue import rit_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd_item i_item,
    output logic      o_ready,
    input  logic      i_pop,
    output logic      o_valid,
    output t_cmd_item o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd_item        r_store [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_store[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_store[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: hdl/rit_back.sv
// back end: entry memory, linear scan engine, record size register, result register
// depends on rit_pkg
module rit_back import rit_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd_item   i_q_item,
    output logic        o_pop,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    t_entry           mem [MAX_ENTRIES];
    t_entry           r_rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [23:0]      r_next_off, n_next_off;
    logic [15:0]      r_step_bytes;
    logic [31:0]      r_key, n_key;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             out_free;
    logic             hit;
    logic [CNT_W-1:0] nxt_idx;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || i_out_ready;
    assign nxt_idx     = r_cmp_idx + CNT_W'(1);
    // finds and deletes match live entries on their key, undeletes match deleted ones on the key they had
    assign hit = (r_rd_data.key == r_key)
              && (r_rd_data.deleted == (r_cmd == CMD_UNDELETE));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_next_off  = r_next_off;
        n_key       = r_key;
        n_cmd       = r_cmd;
        n_cmp_idx   = r_cmp_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_count[IDX_W-1:0];
        mem_wdata   = '{deleted: 1'b0, key: i_q_item.key, offset: r_next_off};
        rd_addr     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop     = 1'b1;
                    n_key     = i_q_item.key;
                    n_cmd     = i_q_item.cmd;
                    n_cmp_idx = '0;
                    unique case (i_q_item.cmd)
                        CMD_STORE: begin
                            n_out_valid = 1'b1;
                            if (r_count == CNT_W'(MAX_ENTRIES)) begin
                                n_out = '{status: ST_FULL, location: 24'd0};
                            end else begin
                                mem_we     = 1'b1;
                                n_out      = '{status: ST_OK, location: r_next_off};
                                n_count    = r_count + CNT_W'(1);
                                n_next_off = r_next_off + {8'd0, r_step_bytes};
                            end
                        end
                        CMD_BAD: begin
                            n_out_valid = 1'b1;
                            n_out       = '{status: ST_MISSING, location: 24'd0};
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out       = '{status: ST_MISSING, location: 24'd0};
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // data of r_cmp_idx is here, the next entry is fetched meanwhile
                rd_addr = nxt_idx[IDX_W-1:0];
                if (hit) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_OK, location: r_rd_data.offset};
                    n_state     = S_IDLE;
                    mem_waddr   = r_cmp_idx[IDX_W-1:0];
                    mem_wdata   = '{deleted: (r_cmd == CMD_DELETE), key: r_rd_data.key,
                                    offset: r_rd_data.offset};
                    mem_we      = (r_cmd == CMD_DELETE) || (r_cmd == CMD_UNDELETE);
                end else if (nxt_idx == r_count) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_MISSING, location: 24'd0};
                    n_state     = S_IDLE;
                end else begin
                    n_cmp_idx = nxt_idx;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_next_off   <= '0;
            r_out_valid  <= 1'b0;
            r_step_bytes <= STEP_BYTES_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_off  <= n_next_off;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_step_bytes <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_cmd     <= n_cmd;
        r_cmp_idx <= n_cmp_idx;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/record_index_table.sv
// record index table: an accepted request is registered in the front stage, queued, and
// answered from the back end's result register; a store or an unused code is answered
// from idle, a lookup scans the entries in order, one entry per memory read, up to the
// hit or to the last stored entry on a miss; the back end takes no new request while it
// scans or while its result is held
// reset (synchronous, active low) empties the table, zeroes the next offset, size 64
module record_index_table import rit_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    logic      front_push;
    t_cmd_item front_item;
    logic      q_ready;
    logic      q_valid;
    logic      q_pop;
    t_cmd_item q_item;

    rit_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (front_push),
        .o_item     (front_item),
        .i_q_ready  (q_ready)
    );

    rit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rit_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (q_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hdl/rit_checker.sv
// port-level checker for the record index table, bound to the top level
// depends on rit_pkg and record_index_table_defines.svh
`include "record_index_table_defines.svh"

module rit_checker import rit_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data
);

    logic in_stall;
    logic out_stall;
    logic out_failed;
    logic status_known;

    assign in_stall     = i_in_valid && !o_in_ready;
    assign out_stall    = o_out_valid && !i_out_ready;
    assign out_failed   = o_out_valid && (o_out_data.status != ST_OK);
    assign status_known = (o_out_data.status == ST_OK) || (o_out_data.status == ST_MISSING)
                       || (o_out_data.status == ST_FULL);

    `RIT_ASSERT_NEXT(a_in_hold, in_stall, i_in_valid && $stable(i_in_data), "request dropped")
    `RIT_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid, "result dropped while stalled")
    `RIT_ASSERT_NEXT(a_out_stable, out_stall, $stable(o_out_data), "result changed on stall")
    `RIT_ASSERT_NOW(a_status_code, o_out_valid, status_known, "bad status code")
    `RIT_ASSERT_NOW(a_fail_loc_zero, out_failed, o_out_data.location == '0, "failed, loc set")

endmodule

bind record_index_table rit_checker u_rit_checker (.*);
